// ===== rtl/bres_pkg.sv =====
package bres_pkg;

   // Field and register widths
   localparam int DIM_BITS       = 11;
   localparam int POS_BITS       = 27;
   localparam int COUNT_BITS     = 10;
   localparam int CHAN_BITS      = 8;
   localparam int CHANNELS       = 3;
   localparam int PIXEL_BITS     = CHAN_BITS * CHANNELS;
   localparam int CLAMP_BITS     = 13;
   localparam int IDX_MAX_BITS   = 12;
   localparam int FRAC_MAX_BITS  = 16;
   localparam int TARGET_MAX     = 1024;

   // Defaults for the top-level parameters
   localparam int MAX_SRC_WIDTH_DEF  = 1024;
   localparam int MAX_SRC_HEIGHT_DEF = 1024;
   localparam int FRAC_BITS_DEF      = 16;
   localparam int QUEUE_DEPTH        = 2;

   // Register port
   localparam int CSR_ADDR_BITS = 5;
   localparam int CSR_DATA_BITS = 32;
   localparam logic [DIM_BITS-1:0] DIM_RESET  = 11'd256;
   localparam logic [POS_BITS-1:0] STEP_RESET = 27'd65536;

   typedef enum logic [2:0] {
      CSR_SRC_WIDTH  = 3'd0,
      CSR_SRC_HEIGHT = 3'd1,
      CSR_TGT_WIDTH  = 3'd2,
      CSR_TGT_HEIGHT = 3'd3,
      CSR_H_STEP     = 3'd4,
      CSR_V_STEP     = 3'd5
   } csr_index_type;

   typedef enum logic {
      OP_LOAD = 1'b0,
      OP_EMIT = 1'b1
   } opcode_type;

   typedef enum logic [2:0] {
      BK_IDLE,
      BK_RD0,
      BK_RD1,
      BK_RD2,
      BK_RD3
   } back_state_type;

   typedef struct packed {
      logic [DIM_BITS-1:0] src_width;
      logic [DIM_BITS-1:0] src_height;
      logic [DIM_BITS-1:0] tgt_width;
      logic [DIM_BITS-1:0] tgt_height;
      logic [POS_BITS-1:0] h_step;
      logic [POS_BITS-1:0] v_step;
   } bres_cfg_type;

   // One classified request as it sits in the queue
   typedef struct packed {
      logic                     is_emit;
      logic [PIXEL_BITS-1:0]    pixel;
      logic [IDX_MAX_BITS-1:0]  xi;
      logic [IDX_MAX_BITS-1:0]  yi;
      logic [FRAC_MAX_BITS-1:0] lx;
      logic [FRAC_MAX_BITS-1:0] ly;
      logic                     hx;
      logic                     vy;
      logic                     row_end;
      logic                     frame_end;
   } bres_cmd_type;

   // Clamp a dimension register into 1..hi
   function automatic logic [CLAMP_BITS-1:0] clamp_dim(input logic [DIM_BITS-1:0] v,
                                                       input logic [CLAMP_BITS-1:0] hi);
      logic [CLAMP_BITS-1:0] ext;
      ext = CLAMP_BITS'(v);
      if (ext == '0) begin
         return CLAMP_BITS'(1);
      end else if (ext > hi) begin
         return hi;
      end
      return ext;
   endfunction

endpackage

// ===== rtl/bres_ram.sv =====
module bres_ram #(
   parameter int WIDTH = 24,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wdata,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   // Write on request, register the read every cycle
   always_ff @(posedge clock) begin
      if (we) begin
         mem[addr] <= wdata;
      end
      rdata_ff <= mem[addr];
   end

   assign rdata = rdata_ff;

endmodule

// ===== rtl/bres_fifo.sv =====
module bres_fifo
   import bres_pkg::*;
#(
   parameter int DEPTH = QUEUE_DEPTH
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         push,
   input  bres_cmd_type push_cmd,
   input  logic         pop,
   output bres_cmd_type head,
   output logic         empty,
   output logic         full
);

   localparam int PTR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_BITS = $clog2(DEPTH + 1);

   bres_cmd_type          slot_ff [DEPTH];
   logic [PTR_BITS-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_BITS-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_BITS-1:0]   count_ff, count_in;

   assign empty = (count_ff == '0);
   assign full  = (count_ff == CNT_BITS'(DEPTH));
   assign head  = slot_ff[rd_ptr_ff];

   // Advance pointers with wrap, track fill level
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_BITS'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_BITS'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_BITS'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_BITS'(1);
      end
      case ({push, pop})
         2'b10:   count_in = count_ff + CNT_BITS'(1);
         2'b01:   count_in = count_ff - CNT_BITS'(1);
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Store the request payload
   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

// ===== rtl/bres_front.sv =====
module bres_front
   import bres_pkg::*;
#(
   parameter int MAX_SRC_WIDTH  = MAX_SRC_WIDTH_DEF,
   parameter int MAX_SRC_HEIGHT = MAX_SRC_HEIGHT_DEF,
   parameter int FRAC_BITS      = FRAC_BITS_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  bres_cfg_type         cfg,
   input  logic                 start,
   output logic                 busy,
   input  logic                 req_opcode,
   input  logic [CHAN_BITS-1:0] req_red_in,
   input  logic [CHAN_BITS-1:0] req_green_in,
   input  logic [CHAN_BITS-1:0] req_blue_in,
   input  logic                 queue_full,
   output logic                 push,
   output bres_cmd_type         push_cmd
);

   localparam int SW_BITS  = $clog2(MAX_SRC_WIDTH + 1);
   localparam int SH_BITS  = $clog2(MAX_SRC_HEIGHT + 1);
   localparam int XR_BITS  = POS_BITS - FRAC_BITS;
   localparam int CMPX_BITS = (XR_BITS > SW_BITS) ? XR_BITS : SW_BITS;
   localparam int CMPY_BITS = (XR_BITS > SH_BITS) ? XR_BITS : SH_BITS;

   logic [SW_BITS-1:0]    sw;
   logic [SH_BITS-1:0]    sh;
   logic [DIM_BITS-1:0]   tw, th;
   logic [POS_BITS-1:0]   col_pos_ff, col_pos_in;
   logic [POS_BITS-1:0]   row_pos_ff, row_pos_in;
   logic [COUNT_BITS-1:0] out_col_ff, out_col_in;
   logic [COUNT_BITS-1:0] out_row_ff, out_row_in;
   logic [CMPX_BITS-1:0]  x_raw, x_lim;
   logic [CMPY_BITS-1:0]  y_raw, y_lim;
   logic                  hx, vy, row_end, frame_end, is_emit;

   assign sw = SW_BITS'(clamp_dim(cfg.src_width, CLAMP_BITS'(MAX_SRC_WIDTH)));
   assign sh = SH_BITS'(clamp_dim(cfg.src_height, CLAMP_BITS'(MAX_SRC_HEIGHT)));
   assign tw = DIM_BITS'(clamp_dim(cfg.tgt_width, CLAMP_BITS'(TARGET_MAX)));
   assign th = DIM_BITS'(clamp_dim(cfg.tgt_height, CLAMP_BITS'(TARGET_MAX)));

   // Accept while the queue has room
   assign busy    = queue_full;
   assign push    = start && !queue_full;
   assign is_emit = (opcode_type'(req_opcode) == OP_EMIT);

   // Split positions, clamp to the last column and row
   assign x_raw = CMPX_BITS'(col_pos_ff[POS_BITS-1:FRAC_BITS]);
   assign x_lim = CMPX_BITS'(sw) - CMPX_BITS'(1);
   assign hx    = (x_raw < x_lim);
   assign y_raw = CMPY_BITS'(row_pos_ff[POS_BITS-1:FRAC_BITS]);
   assign y_lim = CMPY_BITS'(sh) - CMPY_BITS'(1);
   assign vy    = (y_raw < y_lim);

   assign row_end   = (DIM_BITS'(out_col_ff) >= tw - DIM_BITS'(1));
   assign frame_end = row_end && (DIM_BITS'(out_row_ff) >= th - DIM_BITS'(1));

   // Build the queued request
   always_comb begin
      push_cmd.is_emit   = is_emit;
      push_cmd.pixel     = {req_red_in, req_green_in, req_blue_in};
      push_cmd.xi        = IDX_MAX_BITS'(hx ? x_raw : x_lim);
      push_cmd.yi        = IDX_MAX_BITS'(vy ? y_raw : y_lim);
      push_cmd.lx        = FRAC_MAX_BITS'(col_pos_ff[FRAC_BITS-1:0]);
      push_cmd.ly        = FRAC_MAX_BITS'(row_pos_ff[FRAC_BITS-1:0]);
      push_cmd.hx        = hx;
      push_cmd.vy        = vy;
      push_cmd.row_end   = row_end;
      push_cmd.frame_end = frame_end;
   end

   // Step output counters and positions on each emit
   always_comb begin
      col_pos_in = col_pos_ff;
      row_pos_in = row_pos_ff;
      out_col_in = out_col_ff;
      out_row_in = out_row_ff;
      if (push && is_emit) begin
         if (row_end) begin
            out_col_in = '0;
            col_pos_in = '0;
            if (frame_end) begin
               out_row_in = '0;
               row_pos_in = '0;
            end else begin
               out_row_in = out_row_ff + COUNT_BITS'(1);
               row_pos_in = row_pos_ff + cfg.v_step;
            end
         end else begin
            out_col_in = out_col_ff + COUNT_BITS'(1);
            col_pos_in = col_pos_ff + cfg.h_step;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_pos_ff <= '0;
         row_pos_ff <= '0;
         out_col_ff <= '0;
         out_row_ff <= '0;
      end else begin
         col_pos_ff <= col_pos_in;
         row_pos_ff <= row_pos_in;
         out_col_ff <= out_col_in;
         out_row_ff <= out_row_in;
      end
   end

endmodule

// ===== rtl/bres_back.sv =====
module bres_back
   import bres_pkg::*;
#(
   parameter int MAX_SRC_WIDTH  = MAX_SRC_WIDTH_DEF,
   parameter int MAX_SRC_HEIGHT = MAX_SRC_HEIGHT_DEF,
   parameter int FRAC_BITS      = FRAC_BITS_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  bres_cfg_type         cfg,
   input  logic                 queue_empty,
   input  bres_cmd_type         head,
   output logic                 pop,
   output logic                 rsp_valid,
   output logic [CHAN_BITS-1:0] rsp_red_out,
   output logic [CHAN_BITS-1:0] rsp_green_out,
   output logic [CHAN_BITS-1:0] rsp_blue_out,
   output logic                 rsp_row_end,
   output logic                 rsp_frame_end
);

   localparam int SW_BITS   = $clog2(MAX_SRC_WIDTH + 1);
   localparam int SH_BITS   = $clog2(MAX_SRC_HEIGHT + 1);
   localparam int XI_BITS   = $clog2(MAX_SRC_WIDTH);
   localparam int YI_BITS   = $clog2(MAX_SRC_HEIGHT);
   localparam int DEPTH     = MAX_SRC_WIDTH * MAX_SRC_HEIGHT;
   localparam int ADDR_BITS = $clog2(DEPTH);
   localparam int AREA_BITS = SW_BITS + SH_BITS;
   localparam int PROD_BITS = YI_BITS + SW_BITS;
   localparam int FRAC_W1   = FRAC_BITS + 1;
   localparam int MAC_BITS  = FRAC_BITS + CHAN_BITS + 2;
   localparam logic [FRAC_BITS:0] FRAC_ONE = {1'b1, {FRAC_BITS{1'b0}}};

   back_state_type         state_ff, state_in;
   logic [SW_BITS-1:0]     sw;
   logic [SH_BITS-1:0]     sh;
   logic [AREA_BITS-1:0]   area_ff;
   logic [ADDR_BITS-1:0]   load_ptr_ff, load_ptr_in;
   logic                   load_wrap;
   logic [PROD_BITS-1:0]   prod;
   logic [ADDR_BITS-1:0]   base_ff, base_in;
   logic [ADDR_BITS-1:0]   row_off_ff;
   logic                   hx_ff;
   logic [FRAC_BITS-1:0]   lx_ff, ly_ff, tail_ly_ff;
   logic                   rend_ff, fend_ff, tail_rend_ff, tail_fend_ff;
   logic                   tail1_ff, tail2_ff, rsp_valid_ff;
   logic [PIXEL_BITS-1:0]  p_ff, top_ff, bot_ff, rsp_pix_ff;
   logic                   rsp_rend_ff, rsp_fend_ff;
   logic                   ram_we;
   logic [ADDR_BITS-1:0]   ram_addr;
   logic [PIXEL_BITS-1:0]  ram_wdata, ram_rdata;
   logic                   take_emit;

   // One channel: (a*(1-l2) + b*l2) >> FRAC_BITS
   function automatic logic [CHAN_BITS-1:0] blend(input logic [CHAN_BITS-1:0] a,
                                                  input logic [CHAN_BITS-1:0] b,
                                                  input logic [FRAC_BITS-1:0] l2);
      logic [FRAC_BITS:0]  l1;
      logic [MAC_BITS-1:0] acc;
      l1  = FRAC_ONE - FRAC_W1'(l2);
      acc = MAC_BITS'(a) * MAC_BITS'(l1) + MAC_BITS'(b) * MAC_BITS'(l2);
      return acc[FRAC_BITS +: CHAN_BITS];
   endfunction

   function automatic logic [PIXEL_BITS-1:0] blend_px(input logic [PIXEL_BITS-1:0] a,
                                                      input logic [PIXEL_BITS-1:0] b,
                                                      input logic [FRAC_BITS-1:0] l2);
      logic [PIXEL_BITS-1:0] r;
      for (int c = 0; c < CHANNELS; c++) begin
         r[c*CHAN_BITS +: CHAN_BITS] = blend(a[c*CHAN_BITS +: CHAN_BITS],
                                             b[c*CHAN_BITS +: CHAN_BITS], l2);
      end
      return r;
   endfunction

   assign sw = SW_BITS'(clamp_dim(cfg.src_width, CLAMP_BITS'(MAX_SRC_WIDTH)));
   assign sh = SH_BITS'(clamp_dim(cfg.src_height, CLAMP_BITS'(MAX_SRC_HEIGHT)));

   // Frame area for the load pointer wrap
   always_ff @(posedge clock) begin
      area_ff <= AREA_BITS'(sw) * AREA_BITS'(sh);
   end

   assign load_wrap = (AREA_BITS'(load_ptr_ff) + AREA_BITS'(1)) >= area_ff;

   // Base address of the top-left source pixel
   assign prod    = PROD_BITS'(head.yi[YI_BITS-1:0]) * PROD_BITS'(sw);
   assign base_in = ADDR_BITS'(prod) + ADDR_BITS'(head.xi[XI_BITS-1:0]);

   assign take_emit = (state_ff == BK_IDLE) && !queue_empty && head.is_emit;

   // Sequencer: writes each load from idle, address plus four reads per emit
   always_comb begin
      state_in    = state_ff;
      pop         = 1'b0;
      ram_we      = 1'b0;
      ram_addr    = base_ff;
      ram_wdata   = head.pixel;
      load_ptr_in = load_ptr_ff;
      unique case (state_ff)
         BK_IDLE: begin
            if (!queue_empty) begin
               pop = 1'b1;
               if (head.is_emit) begin
                  state_in = BK_RD0;
               end else begin
                  ram_we      = 1'b1;
                  ram_addr    = load_ptr_ff;
                  load_ptr_in = load_wrap ? '0 : load_ptr_ff + ADDR_BITS'(1);
               end
            end
         end
         BK_RD0: begin
            ram_addr = base_ff;
            state_in = BK_RD1;
         end
         BK_RD1: begin
            ram_addr = base_ff + ADDR_BITS'(hx_ff);
            state_in = BK_RD2;
         end
         BK_RD2: begin
            ram_addr = base_ff + row_off_ff;
            state_in = BK_RD3;
         end
         BK_RD3: begin
            ram_addr = base_ff + row_off_ff + ADDR_BITS'(hx_ff);
            state_in = BK_IDLE;
         end
         default: state_in = BK_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BK_IDLE;
         load_ptr_ff  <= '0;
         tail1_ff     <= 1'b0;
         tail2_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         load_ptr_ff  <= load_ptr_in;
         tail1_ff     <= (state_ff == BK_RD3);
         tail2_ff     <= tail1_ff;
         rsp_valid_ff <= tail2_ff;
      end
   end

   // Latch the emit request on pop
   always_ff @(posedge clock) begin
      if (take_emit) begin
         base_ff    <= base_in;
         row_off_ff <= head.vy ? ADDR_BITS'(sw) : '0;
         hx_ff      <= head.hx;
         lx_ff      <= head.lx[FRAC_BITS-1:0];
         ly_ff      <= head.ly[FRAC_BITS-1:0];
         rend_ff    <= head.row_end;
         fend_ff    <= head.frame_end;
      end
   end

   // Collect read data and blend each row horizontally
   always_ff @(posedge clock) begin
      if (state_ff == BK_RD1 || state_ff == BK_RD3) begin
         p_ff <= ram_rdata;
      end
      if (state_ff == BK_RD2) begin
         top_ff <= blend_px(p_ff, ram_rdata, lx_ff);
      end
      if (state_ff == BK_RD3) begin
         tail_ly_ff   <= ly_ff;
         tail_rend_ff <= rend_ff;
         tail_fend_ff <= fend_ff;
      end
      if (tail1_ff) begin
         bot_ff <= blend_px(p_ff, ram_rdata, lx_ff);
      end
      if (tail2_ff) begin
         rsp_pix_ff  <= blend_px(top_ff, bot_ff, tail_ly_ff);
         rsp_rend_ff <= tail_rend_ff;
         rsp_fend_ff <= tail_fend_ff;
      end
   end

   bres_ram #(
      .WIDTH (PIXEL_BITS),
      .DEPTH (DEPTH)
   ) u_frame_store (
      .clock (clock),
      .we    (ram_we),
      .addr  (ram_addr),
      .wdata (ram_wdata),
      .rdata (ram_rdata)
   );

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_red_out   = rsp_pix_ff[2*CHAN_BITS +: CHAN_BITS];
   assign rsp_green_out = rsp_pix_ff[CHAN_BITS +: CHAN_BITS];
   assign rsp_blue_out  = rsp_pix_ff[0 +: CHAN_BITS];
   assign rsp_row_end   = rsp_rend_ff;
   assign rsp_frame_end = rsp_fend_ff;

endmodule

// ===== rtl/bilinear_rgb_resampler_core.sv =====
// Emit path: queue, sequencer states BK_RD0 to BK_RD3, then tail1_ff, tail2_ff and rsp_valid_ff.
// Each emit holds the sequencer for the address multiply plus four reads of the single-port
// frame store; one load per cycle while it is idle. busy rises while the 2-entry queue is
// full. Synchronous reset clears counters, positions, load pointer, queue and registers to
// their defaults; the frame store is not cleared. The receiver cannot stall results.
module bilinear_rgb_resampler_core
   import bres_pkg::*;
#(
   parameter int MAX_SRC_WIDTH  = MAX_SRC_WIDTH_DEF,
   parameter int MAX_SRC_HEIGHT = MAX_SRC_HEIGHT_DEF,
   parameter int FRAC_BITS      = FRAC_BITS_DEF
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   output logic                     busy,
   input  logic                     req_opcode,
   input  logic [CHAN_BITS-1:0]     req_red_in,
   input  logic [CHAN_BITS-1:0]     req_green_in,
   input  logic [CHAN_BITS-1:0]     req_blue_in,
   output logic                     rsp_valid,
   output logic [CHAN_BITS-1:0]     rsp_red_out,
   output logic [CHAN_BITS-1:0]     rsp_green_out,
   output logic [CHAN_BITS-1:0]     rsp_blue_out,
   output logic                     rsp_row_end,
   output logic                     rsp_frame_end,
   input  logic                     psel,
   input  logic                     penable,
   input  logic                     pwrite,
   input  logic [CSR_ADDR_BITS-1:0] paddr,
   input  logic [CSR_DATA_BITS-1:0] pwdata,
   output logic [CSR_DATA_BITS-1:0] prdata,
   output logic                     pready
);

   bres_cfg_type  cfg_ff;
   csr_index_type csr_index;
   logic          csr_write;
   logic          push, pop, fifo_empty, fifo_full;
   bres_cmd_type  push_cmd, head;

   // Register port: pready is always high
   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite && pready;
   assign csr_index = csr_index_type'(paddr[CSR_ADDR_BITS-1:2]);

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.src_width  <= DIM_RESET;
         cfg_ff.src_height <= DIM_RESET;
         cfg_ff.tgt_width  <= DIM_RESET;
         cfg_ff.tgt_height <= DIM_RESET;
         cfg_ff.h_step     <= STEP_RESET;
         cfg_ff.v_step     <= STEP_RESET;
      end else if (csr_write) begin
         unique case (csr_index)
            CSR_SRC_WIDTH:  cfg_ff.src_width  <= pwdata[DIM_BITS-1:0];
            CSR_SRC_HEIGHT: cfg_ff.src_height <= pwdata[DIM_BITS-1:0];
            CSR_TGT_WIDTH:  cfg_ff.tgt_width  <= pwdata[DIM_BITS-1:0];
            CSR_TGT_HEIGHT: cfg_ff.tgt_height <= pwdata[DIM_BITS-1:0];
            CSR_H_STEP:     cfg_ff.h_step     <= pwdata[POS_BITS-1:0];
            CSR_V_STEP:     cfg_ff.v_step     <= pwdata[POS_BITS-1:0];
            default:        ;
         endcase
      end
   end

   // Read back the addressed register
   always_comb begin
      unique case (csr_index)
         CSR_SRC_WIDTH:  prdata = CSR_DATA_BITS'(cfg_ff.src_width);
         CSR_SRC_HEIGHT: prdata = CSR_DATA_BITS'(cfg_ff.src_height);
         CSR_TGT_WIDTH:  prdata = CSR_DATA_BITS'(cfg_ff.tgt_width);
         CSR_TGT_HEIGHT: prdata = CSR_DATA_BITS'(cfg_ff.tgt_height);
         CSR_H_STEP:     prdata = CSR_DATA_BITS'(cfg_ff.h_step);
         CSR_V_STEP:     prdata = CSR_DATA_BITS'(cfg_ff.v_step);
         default:        prdata = '0;
      endcase
   end

   bres_front #(
      .MAX_SRC_WIDTH  (MAX_SRC_WIDTH),
      .MAX_SRC_HEIGHT (MAX_SRC_HEIGHT),
      .FRAC_BITS      (FRAC_BITS)
   ) u_front (
      .clock        (clock),
      .reset        (reset),
      .cfg          (cfg_ff),
      .start        (start),
      .busy         (busy),
      .req_opcode   (req_opcode),
      .req_red_in   (req_red_in),
      .req_green_in (req_green_in),
      .req_blue_in  (req_blue_in),
      .queue_full   (fifo_full),
      .push         (push),
      .push_cmd     (push_cmd)
   );

   bres_fifo #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_cmd (push_cmd),
      .pop      (pop),
      .head     (head),
      .empty    (fifo_empty),
      .full     (fifo_full)
   );

   bres_back #(
      .MAX_SRC_WIDTH  (MAX_SRC_WIDTH),
      .MAX_SRC_HEIGHT (MAX_SRC_HEIGHT),
      .FRAC_BITS      (FRAC_BITS)
   ) u_back (
      .clock         (clock),
      .reset         (reset),
      .cfg           (cfg_ff),
      .queue_empty   (fifo_empty),
      .head          (head),
      .pop           (pop),
      .rsp_valid     (rsp_valid),
      .rsp_red_out   (rsp_red_out),
      .rsp_green_out (rsp_green_out),
      .rsp_blue_out  (rsp_blue_out),
      .rsp_row_end   (rsp_row_end),
      .rsp_frame_end (rsp_frame_end)
   );

   // A frame always ends on a row end
   a_frame_end_row_end: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_frame_end |-> rsp_row_end)
      else $error("frame end without row end");

   // Emits occupy the sequencer through states BK_RD0 to BK_RD3, so strobes never touch
   a_rsp_spacing: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("result strobes in consecutive cycles");

   // An accepted request is held in the queue
   a_accept_queued: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> !fifo_empty)
      else $error("accepted request missing from queue");

endmodule
